[src/lprd_pkg.sv]
// ----------------------------------------------------------------------------
// lprd_pkg
// shared types, constants and the prefix table of the record deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lprd_pkg;

  localparam int unsigned DefLengthBits = 24;
  localparam int unsigned RecLenW       = 24;

  localparam logic [3:0] PrefixLen  = 4'd12;
  localparam logic [3:0] PosNoDigit = 4'd12;
  localparam logic [3:0] PosDigits  = 4'd13;
  localparam logic [1:0] TrailerLen = 2'd2;

  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  typedef enum logic [1:0] {
    KindSilent  = 2'd0,
    KindPayload = 2'd1,
    KindHeader  = 2'd2,
    KindError   = 2'd3
  } kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           payload_byte;
    logic                 last_payload;
    logic [RecLenW-1:0]   record_length;
  } res_t;

  // "+HTTPCLIENT:"
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = CharPlus;
      4'd1:    c = 8'h48;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h43;
      4'd6:    c = 8'h4C;
      4'd7:    c = 8'h49;
      4'd8:    c = 8'h45;
      4'd9:    c = 8'h4E;
      4'd10:   c = 8'h54;
      4'd11:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[src/lprd_in_reg.sv]
// ----------------------------------------------------------------------------
// lprd_in_reg
// input register, holds one beat until the core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_in_reg
  import lprd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

[src/lprd_core.sv]
// ----------------------------------------------------------------------------
// lprd_core
// deframing state and the per-beat decision logic
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_core
  import lprd_pkg::*;
#(
  parameter int unsigned LengthBits = DefLengthBits
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  fire_i,
  input  wire item_t item_i,
  output res_t       res_o
);

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhTrailer = 2'd2,
    PhUnused  = 2'd3
  } phase_e;

  localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};

  phase_e                phase_q, phase_d;
  logic [3:0]            pos_q, pos_d;
  logic [LengthBits-1:0] acc_q, acc_d;
  logic [LengthBits-1:0] rem_q, rem_d;
  logic [1:0]            trl_q, trl_d;

  logic [7:0]              b;
  logic [3:0]              diff;
  logic [LengthBits+3:0]   acc_x10;
  logic [LengthBits-1:0]   acc_sat;
  logic [LengthBits-1:0]   rem_dec;
  logic [1:0]              trl_dec;
  logic [LengthBits+23:0]  acc_wide;
  logic                    is_digit;

  assign b        = item_i.rx_byte;
  assign diff     = 4'(b - CharZero);
  assign is_digit = b inside {[CharZero:CharNine]};
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{LengthBits{1'b0}}, diff};
  assign acc_sat  = (acc_x10[LengthBits+3:LengthBits] != 4'd0) ? LenMax
                                                               : acc_x10[LengthBits-1:0];
  assign rem_dec  = (rem_q != '0) ? rem_q - {{(LengthBits-1){1'b0}}, 1'b1} : rem_q;
  assign trl_dec  = (trl_q != 2'd0) ? trl_q - 2'd1 : trl_q;
  assign acc_wide = {{RecLenW{1'b0}}, acc_q};

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    trl_d   = trl_q;
    res_o   = '{kind: KindSilent, payload_byte: 8'd0, last_payload: 1'b0,
                record_length: '0};
    if (fire_i) begin
      if (item_i.action) begin
        phase_d = PhHeader;
        pos_d   = 4'd0;
        acc_d   = '0;
        rem_d   = '0;
        trl_d   = 2'd0;
      end else begin
        case (phase_q)
          PhPayload: begin
            res_o.kind         = KindPayload;
            res_o.payload_byte = b;
            rem_d              = rem_dec;
            if (rem_dec == '0) begin
              res_o.last_payload = 1'b1;
              phase_d            = PhTrailer;
              trl_d              = TrailerLen;
            end
          end
          PhTrailer: begin
            trl_d = trl_dec;
            if (trl_dec == 2'd0) begin
              phase_d = PhHeader;
            end
          end
          default: begin
            phase_d = PhHeader;
            if (pos_q < PrefixLen) begin
              if (b == prefix_char(pos_q)) begin
                pos_d = pos_q + 4'd1;
              end else begin
                res_o.kind = KindError;
                acc_d      = '0;
                pos_d      = (b == CharPlus) ? 4'd1 : 4'd0;
              end
            end else if (is_digit) begin
              acc_d = acc_sat;
              pos_d = PosDigits;
            end else if (b == CharComma && pos_q == PosDigits) begin
              res_o.kind          = KindHeader;
              res_o.record_length = acc_wide[RecLenW-1:0];
              rem_d               = acc_q;
              acc_d               = '0;
              pos_d               = 4'd0;
              if (acc_q == '0) begin
                phase_d = PhTrailer;
                trl_d   = TrailerLen;
              end else begin
                phase_d = PhPayload;
              end
            end else begin
              res_o.kind = KindError;
              acc_d      = '0;
              pos_d      = (b == CharPlus) ? 4'd1 : 4'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= 4'd0;
      acc_q   <= '0;
      rem_q   <= '0;
      trl_q   <= 2'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      trl_q   <= trl_d;
    end
  end

endmodule

`default_nettype wire

[src/lprd_out_reg.sv]
// ----------------------------------------------------------------------------
// lprd_out_reg
// result register toward the output channel
// ----------------------------------------------------------------------------
`default_nettype none

module lprd_out_reg
  import lprd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  output logic      space_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

[src/length_prefixed_record_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer
// cuts "+HTTPCLIENT:<len>," records out of a received byte stream
// ----------------------------------------------------------------------------
// Takes one beat per cycle when the output is not stalled and gives exactly one
// result beat for each input beat. Each beat passes an input register, one step
// of the deframing state (prefix compare, decimal length update by
// shift-and-add with saturation at 2^LengthBits-1, or a payload/trailer count)
// and a result register. The result register frees while it is being read, so
// an item can enter every cycle. A beat with action set restarts the header
// search; no clearing pass follows reset.
`default_nettype none

module length_prefixed_record_deframer
  import lprd_pkg::*;
#(
  parameter int unsigned LengthBits = DefLengthBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               action_i,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic [7:0]              payload_byte_o,
  output logic                    last_payload_o,
  output logic [RecLenW-1:0]      record_length_o
);

  item_t in_item;
  item_t reg_item;
  logic  reg_valid;
  logic  space;
  logic  fire;
  res_t  core_res;
  res_t  out_res;

  assign in_item = '{action: action_i, rx_byte: rx_byte_i};
  assign fire    = reg_valid && space;

  lprd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .take_i  (fire),
    .valid_o (reg_valid),
    .item_o  (reg_item)
  );

  lprd_core #(
    .LengthBits (LengthBits)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (reg_item),
    .res_o  (core_res)
  );

  lprd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (core_res),
    .space_o (space),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (out_res)
  );

  assign kind_o          = out_res.kind;
  assign payload_byte_o  = out_res.payload_byte;
  assign last_payload_o  = out_res.last_payload;
  assign record_length_o = out_res.record_length;

endmodule

`default_nettype wire

[test/tb_length_prefixed_record_deframer.sv]
// ----------------------------------------------------------------------------
// tb_length_prefixed_record_deframer
// self-checking bench for the "+HTTPCLIENT:<len>," record deframer
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes comes first: error, restart and header
// beats carry their expected result in the table, and the rest are checked by
// an in-bench tracker of the deframing state. Random traffic follows. Most of
// it is whole records with random lengths and payload, and the rest is broken
// headers, non-digit lengths, bare commas, saturating lengths, restarts inside
// records and plain noise. Both handshakes idle at random, and every result
// beat is compared field by field, in order, with its expected result.
`timescale 1ns / 100ps
`default_nettype none

module tb_length_prefixed_record_deframer;
  import lprd_pkg::*;

  localparam int ItemsTarget = 2000;
  localparam int TagLen = 12;
  localparam logic [8*TagLen-1:0] HdrTag = "+HTTPCLIENT:";
  localparam longint unsigned LenMax = (64'd1 << DefLengthBits) - 1;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhTrailer = 2'd2
  } phase_e;

  typedef struct packed {
    logic               act;
    logic [7:0]         val;
    logic               pin;
    kind_e              kind;
    logic [RecLenW-1:0] len;
  } probe_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               action_i;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         kind_o;
  logic [7:0]         payload_byte_o;
  logic               last_payload_o;
  logic [RecLenW-1:0] record_length_o;

  // deframing state tracked by the bench
  phase_e             ph;
  logic [3:0]         pos;
  logic [RecLenW-1:0] acc;
  logic [RecLenW-1:0] rem_bytes;
  logic [1:0]         rem_trailer;

  res_t due_results[$];
  res_t pin_res;
  bit   pin_next;
  bit   tx_calm;
  bit   rx_calm;
  int   sent;
  int   faults;

  probe_t probes [22] = '{
    '{1'b0, 8'h00, 1'b1, KindError,  24'd0},
    '{1'b0, 8'hFF, 1'b1, KindError,  24'd0},
    '{1'b1, 8'hFF, 1'b1, KindSilent, 24'd0},
    '{1'b1, 8'h00, 1'b1, KindSilent, 24'd0},
    '{1'b0, "+",   1'b0, KindSilent, 24'd0},
    '{1'b0, "+",   1'b1, KindError,  24'd0},
    '{1'b0, "H",   1'b0, KindSilent, 24'd0},
    '{1'b0, "T",   1'b0, KindSilent, 24'd0},
    '{1'b0, "T",   1'b0, KindSilent, 24'd0},
    '{1'b0, "P",   1'b0, KindSilent, 24'd0},
    '{1'b0, "C",   1'b0, KindSilent, 24'd0},
    '{1'b0, "L",   1'b0, KindSilent, 24'd0},
    '{1'b0, "I",   1'b0, KindSilent, 24'd0},
    '{1'b0, "E",   1'b0, KindSilent, 24'd0},
    '{1'b0, "N",   1'b0, KindSilent, 24'd0},
    '{1'b0, "T",   1'b0, KindSilent, 24'd0},
    '{1'b0, ":",   1'b0, KindSilent, 24'd0},
    '{1'b0, "0",   1'b0, KindSilent, 24'd0},
    '{1'b0, ",",   1'b1, KindHeader, 24'd0},
    '{1'b0, 8'hFF, 1'b0, KindSilent, 24'd0},
    '{1'b0, 8'h00, 1'b0, KindSilent, 24'd0},
    '{1'b0, ",",   1'b1, KindError,  24'd0}
  };

  length_prefixed_record_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .payload_byte_o  (payload_byte_o),
    .last_payload_o  (last_payload_o),
    .record_length_o (record_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [7:0] tag_char(input int p);
    return HdrTag[8*(TagLen-1-p) +: 8];
  endfunction

  function automatic void clear_tracker();
    ph          = PhHeader;
    pos         = '0;
    acc         = '0;
    rem_bytes   = '0;
    rem_trailer = '0;
  endfunction

  function automatic void drop_header(input logic [7:0] b);
    acc = '0;
    pos = (b == CharPlus) ? 4'd1 : 4'd0;
    ph  = PhHeader;
  endfunction

  function automatic res_t deframe_byte(input logic act, input logic [7:0] b);
    res_t r;
    longint unsigned grown;
    r = '{KindSilent, 8'h00, 1'b0, '0};
    if (act) begin
      clear_tracker();
    end else begin
      case (ph)
        PhPayload: begin
          r.kind = KindPayload;
          r.payload_byte = b;
          if (rem_bytes != 0) rem_bytes--;
          if (rem_bytes == 0) begin
            r.last_payload = 1'b1;
            ph = PhTrailer;
            rem_trailer = TrailerLen;
          end
        end
        PhTrailer: begin
          if (rem_trailer != 0) rem_trailer--;
          if (rem_trailer == 0) ph = PhHeader;
        end
        default: begin
          ph = PhHeader;
          if (pos < PrefixLen) begin
            if (b == tag_char(pos)) begin
              pos++;
            end else begin
              r.kind = KindError;
              drop_header(b);
            end
          end else if (b >= CharZero && b <= CharNine) begin
            grown = longint'(acc) * 10 + longint'(b - CharZero);
            if (grown > LenMax) grown = LenMax;
            acc = grown[RecLenW-1:0];
            pos = PosDigits;
          end else if (b == CharComma && pos == PosDigits) begin
            r.kind = KindHeader;
            r.record_length = acc;
            rem_bytes = acc;
            acc = '0;
            pos = '0;
            if (rem_bytes == 0) begin
              ph = PhTrailer;
              rem_trailer = TrailerLen;
            end else begin
              ph = PhPayload;
            end
          end else begin
            r.kind = KindError;
            drop_header(b);
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // called at a rising edge; returns at the edge that takes the beat
  task automatic drive_beat(input logic act, input logic [7:0] b);
    int   gap;
    res_t due;
    gap = idle_len(tx_calm);
    if ($urandom_range(0, 63) == 0) tx_calm = ~tx_calm;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= b;
    do @(negedge clk_i); while (!in_ready_o);
    due = deframe_byte(act, b);
    if (pin_next) begin
      due = pin_res;
      pin_next = 1'b0;
    end
    due_results.push_back(due);
    sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  task automatic send_prefix(input int k);
    for (int i = 0; i < k; i++) drive_beat(1'b0, tag_char(i));
  endtask

  task automatic send_length(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) drive_beat(1'b0, s[i]);
  endtask

  task automatic send_payload(input int n);
    for (int i = 0; i < n; i++) drive_beat(1'b0, 8'($urandom_range(0, 255)));
  endtask

  task automatic flag_fault(input string what, input res_t w);
    faults++;
    if (faults <= 10) begin
      $display("%s: want %0d/%02h/%0b/%0d got %0d/%02h/%0b/%0d",
               what, w.kind, w.payload_byte, w.last_payload, w.record_length,
               kind_o, payload_byte_o, last_payload_o, record_length_o);
    end
  endtask

  // result beats are taken at the next rising edge
  always @(negedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        want = '{KindSilent, 8'h00, 1'b0, '0};
        flag_fault("unexpected beat", want);
      end else begin
        want = due_results.pop_front();
        if (kind_o != want.kind || payload_byte_o != want.payload_byte ||
            last_payload_o != want.last_payload || record_length_o != want.record_length) begin
          flag_fault("mismatch", want);
        end
      end
    end
  end

  initial begin
    int n;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      n = idle_len(rx_calm);
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 63) == 0) rx_calm = ~rx_calm;
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int         pick;
    int         n;
    int         k;
    logic [7:0] bad;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= 1'b0;
    rx_byte_i  <= 8'h00;
    pin_next = 1'b0;
    tx_calm  = 1'b0;
    sent     = 0;
    faults   = 0;
    clear_tracker();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].pin) begin
        pin_res  = '{probes[i].kind, 8'h00, 1'b0, probes[i].len};
        pin_next = 1'b1;
      end
      drive_beat(probes[i].act, probes[i].val);
    end
    drain();

    while (sent < ItemsTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        k = $urandom_range(0, 99);
        n = (k < 10) ? 0 : (k < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        send_prefix(TagLen);
        if ($urandom_range(0, 7) == 0) drive_beat(1'b0, CharZero);
        send_length(n);
        drive_beat(1'b0, CharComma);
        send_payload(n);
        if ($urandom_range(0, 1) == 0) begin
          drive_beat(1'b0, 8'h0D);
          drive_beat(1'b0, 8'h0A);
        end else begin
          send_payload(2);
        end
      end else if (pick < 76) begin
        // broken prefix
        k = $urandom_range(0, TagLen - 1);
        send_prefix(k);
        if (k != 0 && $urandom_range(0, 3) == 0) begin
          bad = CharPlus;
        end else begin
          do bad = 8'($urandom_range(0, 255)); while (bad == tag_char(k));
        end
        drive_beat(1'b0, bad);
      end else if (pick < 82) begin
        // stray byte inside the length
        send_prefix(TagLen);
        repeat ($urandom_range(0, 3)) drive_beat(1'b0, CharZero + 8'($urandom_range(0, 9)));
        do bad = 8'($urandom_range(0, 255));
        while ((bad >= CharZero && bad <= CharNine) || bad == CharComma);
        drive_beat(1'b0, bad);
      end else if (pick < 86) begin
        send_prefix(TagLen);
        drive_beat(1'b0, CharComma);
      end else if (pick < 91) begin
        // saturating length, cut short by a restart
        send_prefix(TagLen);
        if ($urandom_range(0, 2) == 0) begin
          send_length(int'(LenMax));
        end else begin
          drive_beat(1'b0, CharZero + 8'($urandom_range(1, 9)));
          repeat ($urandom_range(7, 10)) drive_beat(1'b0, CharZero + 8'($urandom_range(0, 9)));
        end
        drive_beat(1'b0, CharComma);
        send_payload($urandom_range(1, 4));
        drive_beat(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        // restart inside a record
        n = $urandom_range(1, 8);
        send_prefix($urandom_range(1, TagLen));
        if ($urandom_range(0, 1) == 0) begin
          send_prefix(0);
        end
        if (pos >= PrefixLen) begin
          send_length(n);
          drive_beat(1'b0, CharComma);
          send_payload($urandom_range(0, n - 1));
        end
        drive_beat(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          drive_beat($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 24) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (faults == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
